FILE: hdl/u8d_pkg.sv
// Shared types and constants of the UTF-8 byte stream decoder.
package u8d_pkg;

    // Width of a decoded code point.
    localparam int unsigned CP_W = 21;

    // Result slots per bundle; one input byte completes at most three code points.
    localparam int unsigned MAX_PTS = 4;

    // Width of the padded output data word.
    localparam int unsigned TDATA_OUT_W = 24;

    // One decoded result before it leaves the block.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            valid;
    } t_point;

    // All results caused by one input item, in output order.
    typedef struct packed {
        t_point [MAX_PTS-1:0] pts;
        logic [1:0]           last_idx;
        logic                 done;
    } t_bundle;

endpackage

FILE: hdl/utf8_byte_stream_decoder_core.sv
// Top level of the UTF-8 byte stream decoder: front end, bundle queue, output side.
//
// The input channel takes one byte of UTF-8 text per item on s_axis_tdata, with
// s_axis_tlast high on the final byte of a text. The output channel gives one
// code point per item on m_axis_tdata; m_axis_tuser is high when the item holds
// a decoded value and low for an end-only marker; m_axis_tlast marks the last
// result of a text. A byte may complete zero to three code points.
// Throughput is one input byte per cycle as long as results drain at the same
// rate; the output side sends one result per cycle while m_axis_tready is
// high, so a byte that completes several results takes one output item for
// each. Bytes are decoded by the front end in the cycle they are accepted and
// the results are written as one bundle into a queue of QUEUE_DEPTH entries.
// When the receiver stalls, the queue fills and s_axis_tready drops once it
// is full; no result is lost. Reset clears the pending bytes and empties the
// queue.
module utf8_byte_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,  // [0] point_valid
    output logic        m_axis_tlast
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             nonempty;
    u8d_pkg::t_bundle bundle_in;
    u8d_pkg::t_bundle bundle_head;

    // Accept a byte whenever the queue has room for its bundle.
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_push   (push),
        .o_bundle (bundle_in)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (bundle_in),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (bundle_head)
    );

    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nonempty    (nonempty),
        .i_head        (bundle_head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: hdl/u8d_front.sv
// Front end: holds pending bytes, decodes each incoming byte into a result bundle.
module u8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output logic            o_push,
    output u8d_pkg::t_bundle o_bundle
);

    // Pending bytes of an incomplete form; the first one is always a lead.
    logic [7:0] r_held [3];
    logic [1:0] r_held_cnt;
    logic [7:0] n_held [3];
    logic [1:0] n_held_cnt;

    // Working window and per-position decode.
    logic [7:0]      win     [4];
    logic [2:0]      need    [4];
    logic            cont_ok [4];
    logic [20:0]     cp_at   [4];
    logic            legal   [4];
    logic [2:0]      num;

    // Length of the form that a lead byte opens; zero for bytes that cannot lead.
    function automatic logic [2:0] form_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Build the window: held bytes followed by the new byte.
    always_comb begin
        num = {1'b0, r_held_cnt} + 3'd1;
        for (int i = 0; i < 3; i++) begin
            win[i] = (r_held_cnt == 2'(i)) ? i_byte : r_held[i];
        end
        win[3] = i_byte;
    end

    // Decode a form starting at every position of the window in parallel.
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            logic [7:0] b3;
            b0 = win[2'(p)];
            b1 = win[2'(p + 1)];
            b2 = win[2'(p + 2)];
            b3 = win[2'(p + 3)];
            need[p] = form_len(b0);
            cont_ok[p] = 1'b1;
            if (need[p] >= 3'd2 && b1[7:6] != 2'b10) cont_ok[p] = 1'b0;
            if (need[p] >= 3'd3 && b2[7:6] != 2'b10) cont_ok[p] = 1'b0;
            if (need[p] >= 3'd4 && b3[7:6] != 2'b10) cont_ok[p] = 1'b0;
            case (need[p])
                3'd1:    cp_at[p] = {13'd0, b0};
                3'd2:    cp_at[p] = {10'd0, b0[4:0], b1[5:0]};
                3'd3:    cp_at[p] = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                3'd4:    cp_at[p] = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default: cp_at[p] = '0;
            endcase
            // Reject values beyond the Unicode range and the surrogate block.
            legal[p] = (cp_at[p] <= 21'h10FFFF) &&
                       !((cp_at[p] >= 21'h00D800) && (cp_at[p] <= 21'h00DFFF));
        end
    end

    // Walk the window from the front, collecting results and what is left over.
    always_comb begin
        logic [2:0] pos;
        logic [2:0] cnt;
        logic       stop;
        logic [1:0] idx;
        logic [2:0] rem;
        pos = 3'd0;
        cnt = 3'd0;
        stop = 1'b0;
        idx = 2'd0;
        o_bundle = '0;
        for (int s = 0; s < 4; s++) begin
            if (!stop && pos < num) begin
                idx = pos[1:0];
                case (need[idx])
                    3'd0: begin
                        pos = pos + 3'd1;
                    end
                    3'd1: begin
                        o_bundle.pts[cnt[1:0]] = '{cp: cp_at[idx], valid: 1'b1};
                        cnt = cnt + 3'd1;
                        pos = pos + 3'd1;
                    end
                    default: begin
                        if ((num - pos) < need[idx]) begin
                            stop = 1'b1;
                        end else if (!cont_ok[idx]) begin
                            // Only the lead is dropped; the rest is scanned again.
                            pos = pos + 3'd1;
                        end else begin
                            pos = pos + need[idx];
                            if (legal[idx]) begin
                                o_bundle.pts[cnt[1:0]] = '{cp: cp_at[idx], valid: 1'b1};
                                cnt = cnt + 3'd1;
                            end
                        end
                    end
                endcase
            end
        end

        // The end of a text with no result still gives an end marker.
        if (i_end && cnt == 3'd0) begin
            o_bundle.pts[0] = '{cp: '0, valid: 1'b0};
            cnt = 3'd1;
        end
        o_bundle.last_idx = 2'(cnt - 3'd1);
        o_bundle.done = i_end;
        o_push = i_accept && (cnt != 3'd0);

        // Keep the unfinished tail unless the text ends here.
        rem = stop ? (num - pos) : 3'd0;
        n_held_cnt = i_end ? 2'd0 : rem[1:0];
        for (int i = 0; i < 3; i++) begin
            n_held[i] = win[2'(pos[1:0] + 2'(i))];
        end
    end

    // Pending byte state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= n_held[i];
            end
        end
    end

endmodule

FILE: hdl/u8d_queue.sv
// Short queue of result bundles between the front end and the output side.
module u8d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8d_pkg::t_bundle i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output u8d_pkg::t_bundle o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u8d_pkg::t_bundle r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_slots[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Bundle storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/u8d_back.sv
// Output side: sends the results of each queued bundle one item at a time.
module u8d_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_nonempty,
    input  u8d_pkg::t_bundle                  i_head,
    output logic                              o_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [u8d_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    logic [1:0]      r_idx;
    logic            last_of_bundle;
    logic            fire;
    u8d_pkg::t_point cur;

    // Present the current result of the head bundle.
    always_comb begin
        cur            = i_head.pts[r_idx];
        last_of_bundle = (r_idx == i_head.last_idx);
        fire           = i_nonempty && m_axis_tready;
        m_axis_tvalid  = i_nonempty;
        m_axis_tdata   = {{(u8d_pkg::TDATA_OUT_W - u8d_pkg::CP_W){1'b0}}, cur.cp};
        m_axis_tuser   = cur.valid;
        m_axis_tlast   = i_head.done && last_of_bundle;
        o_pop          = fire && last_of_bundle;
    end

    // Step through the bundle; release it after its last result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= last_of_bundle ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule
